// ===== hdl/kab_pkg.sv =====
// shared types, codes and saturation helpers of the angle and bias filter
package kab_pkg;

	localparam int OPW = 48;

	typedef enum logic [1:0] {
		REG_Q_ANGLE     = 2'd0,
		REG_Q_BIAS      = 2'd1,
		REG_R_MEASURE   = 2'd2,
		REG_START_ANGLE = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		OP_RATE  = 4'd0,
		OP_M_ANG = 4'd1,
		OP_M_D11 = 4'd2,
		OP_INNER = 4'd3,
		OP_M_P00 = 4'd4,
		OP_M_P11 = 4'd5,
		OP_S     = 4'd6,
		OP_D_K0  = 4'd7,
		OP_D_K1  = 4'd8,
		OP_Y     = 4'd9,
		OP_M_CA  = 4'd10,
		OP_M_CB  = 4'd11,
		OP_M_C00 = 4'd12,
		OP_M_C10 = 4'd13,
		OP_M_C01 = 4'd14,
		OP_M_C11 = 4'd15
	} op_t;

	localparam int NUM_OPS = 16;

	typedef struct packed {
		logic start;
		logic wb;
		logic load;
		logic emit;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic out_free;
	} status_t;

	function automatic logic op_is_alu(input op_t op);
		return (op == OP_RATE) || (op == OP_INNER) || (op == OP_S) || (op == OP_Y);
	endfunction

	function automatic logic op_is_div(input op_t op);
		return (op == OP_D_K0) || (op == OP_D_K1);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sh7FFFFFFF) return 32'sh7FFFFFFF;
		if (v < -66'sh80000000) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [39:0] sat40(input logic signed [65:0] v);
		if (v > 66'sh7FFFFFFFFF) return 40'sh7FFFFFFFFF;
		if (v < -66'sh8000000000) return 40'sh8000000000;
		return v[39:0];
	endfunction

endpackage

// ===== hdl/kab_mul.sv =====
// multi-cycle signed multiplier with rounding shift and magnitude cap
module kab_mul import kab_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic signed [OPW-1:0]  a,
	input  logic signed [OPW-1:0]  b,
	input  logic                   sh30,
	output logic                   done,
	output logic signed [63:0]     res
);

	localparam logic [96:0] LIM = 97'(1) << 62;

	logic           busy_q;
	logic [2:0]     ph_q;
	logic           done_q;
	logic [OPW-1:0] ua_q;
	logic [OPW-1:0] ub_q;
	logic           neg_q;
	logic           sh_q;
	logic [95:0]    acc_q;
	logic [96:0]    quot_q;
	logic signed [63:0] res_q;

	logic [15:0]    chunk;
	logic [95:0]    pp;
	logic [96:0]    sum;
	logic [62:0]    capped;

	always_comb begin
		case (ph_q[1:0])
			2'd0:    chunk = ub_q[15:0];
			2'd1:    chunk = ub_q[31:16];
			default: chunk = ub_q[47:32];
		endcase
		pp = 96'(ua_q) * 96'(chunk);
		case (ph_q[1:0])
			2'd0:    pp = pp;
			2'd1:    pp = pp << 16;
			default: pp = pp << 32;
		endcase
		sum = {1'b0, acc_q} + (sh_q ? (97'(1) << 29) : (97'(1) << 15));
		capped = (quot_q > LIM) ? LIM[62:0] : quot_q[62:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ph_q   <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				ph_q   <= '0;
			end else if (busy_q) begin
				ph_q <= ph_q + 3'd1;
				if (ph_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ua_q  <= a[OPW-1] ? OPW'(-a) : OPW'(a);
			ub_q  <= b[OPW-1] ? OPW'(-b) : OPW'(b);
			neg_q <= a[OPW-1] ^ b[OPW-1];
			sh_q  <= sh30;
			acc_q <= '0;
		end else if (busy_q) begin
			if (ph_q <= 3'd2) begin
				acc_q <= acc_q + pp;
			end else if (ph_q == 3'd3) begin
				quot_q <= sh_q ? (sum >> 30) : (sum >> 16);
			end else begin
				res_q <= neg_q ? -64'(capped) : 64'(capped);
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// ===== hdl/kab_div.sv =====
// bit-serial signed divider giving a saturated Q2.30 quotient
module kab_div import kab_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [39:0]  num,
	input  logic signed [41:0]  den,
	output logic                done,
	output logic signed [31:0]  res
);

	logic        busy_q;
	logic        fin_q;
	logic [6:0]  cnt_q;
	logic        done_q;
	logic [69:0] dvd_q;
	logic [41:0] ud_q;
	logic [42:0] rem_q;
	logic [32:0] quo_q;
	logic        ovf_q;
	logic        neg_q;
	logic signed [31:0] res_q;

	logic [42:0] rem_sh;
	logic        qbit;
	logic        quo_big;

	always_comb begin
		rem_sh  = {rem_q[41:0], dvd_q[69]};
		qbit    = rem_sh >= {1'b0, ud_q};
		quo_big = ovf_q | quo_q[32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			fin_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd69;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd0) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {(num[39] ? 40'(-num) : 40'(num)), 30'b0};
			ud_q  <= den[41] ? 42'(-den) : 42'(den);
			neg_q <= num[39] ^ den[41];
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[68:0], 1'b0};
			rem_q <= qbit ? rem_sh - {1'b0, ud_q} : rem_sh;
			ovf_q <= ovf_q | quo_q[32];
			quo_q <= {quo_q[31:0], qbit};
		end else if (fin_q) begin
			if (ud_q == '0) begin
				res_q <= '0;
			end else if (neg_q) begin
				res_q <= (quo_big || quo_q[31]) ? 32'sh80000000 : -quo_q[31:0];
			end else begin
				res_q <= (quo_big || quo_q[31]) ? 32'sh7FFFFFFF : quo_q[31:0];
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// ===== hdl/kab_datapath.sv =====
// filter state, configuration registers and arithmetic units
module kab_datapath import kab_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output status_t             status,
	input  logic                cfg_valid,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic signed [31:0]  measured_angle,
	input  logic signed [31:0]  measured_rate,
	input  logic [15:0]         time_step,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  filtered_angle,
	output logic signed [31:0]  unbiased_rate
);

	logic [31:0]        q_angle_q;
	logic [31:0]        q_bias_q;
	logic [31:0]        r_measure_q;
	logic signed [31:0] angle_q;
	logic signed [31:0] bias_q;
	logic signed [31:0] rate_q;
	logic signed [39:0] p_q [4];
	logic signed [31:0] k0_q;
	logic signed [31:0] k1_q;
	logic signed [32:0] y_q;
	logic signed [39:0] d11_q;
	logic signed [42:0] inner_q;
	logic signed [41:0] s_q;
	logic signed [39:0] tmp_q;
	logic signed [31:0] meas_q;
	logic signed [31:0] rin_q;
	logic [15:0]        dt_q;
	logic               out_valid_q;
	logic signed [31:0] fa_q;
	logic signed [31:0] ur_q;

	logic signed [OPW-1:0] ma;
	logic signed [OPW-1:0] mb;
	logic                  msh;
	logic                  mstart;
	logic                  mdone;
	logic signed [63:0]    mres;
	logic signed [39:0]    dnum;
	logic                  dstart;
	logic                  ddone;
	logic signed [31:0]    dres;
	logic signed [OPW-1:0] dt_x;

	assign dt_x   = OPW'({1'b0, dt_q});
	assign mstart = cmd.start && !op_is_alu(cmd.op) && !op_is_div(cmd.op);
	assign dstart = cmd.start && op_is_div(cmd.op);
	assign dnum   = (cmd.op == OP_D_K1) ? p_q[2] : p_q[0];

	always_comb begin
		ma  = dt_x;
		mb  = OPW'(rate_q);
		msh = 1'b0;
		unique case (cmd.op)
			OP_M_ANG: mb = OPW'(rate_q);
			OP_M_D11: mb = OPW'(p_q[3]);
			OP_M_P00: mb = OPW'(inner_q);
			OP_M_P11: begin
				ma = OPW'({8'b0, q_bias_q, 8'b0});
				mb = dt_x;
			end
			OP_M_CA: begin
				ma = OPW'(k0_q); mb = OPW'(y_q); msh = 1'b1;
			end
			OP_M_CB: begin
				ma = OPW'(k1_q); mb = OPW'(y_q); msh = 1'b1;
			end
			OP_M_C00: begin
				ma = OPW'(k0_q); mb = OPW'(p_q[0]); msh = 1'b1;
			end
			OP_M_C10: begin
				ma = OPW'(k1_q); mb = OPW'(p_q[0]); msh = 1'b1;
			end
			OP_M_C01: begin
				ma = OPW'(k0_q); mb = OPW'(p_q[1]); msh = 1'b1;
			end
			OP_M_C11: begin
				ma = OPW'(k1_q); mb = OPW'(p_q[1]); msh = 1'b1;
			end
			default: ;
		endcase
	end

	kab_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mstart), .a(ma), .b(mb),
		.sh30(msh), .done(mdone), .res(mres)
	);

	kab_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .num(dnum), .den(s_q),
		.done(ddone), .res(dres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_angle_q   <= 32'd16777;
			q_bias_q    <= 32'd50332;
			r_measure_q <= 32'd503316;
			angle_q     <= '0;
			bias_q      <= '0;
			rate_q      <= '0;
			p_q[0]      <= '0;
			p_q[1]      <= '0;
			p_q[2]      <= '0;
			p_q[3]      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (reg_idx_t'(cfg_index))
					REG_Q_ANGLE:     q_angle_q <= cfg_data;
					REG_Q_BIAS:      q_bias_q <= cfg_data;
					REG_R_MEASURE:   r_measure_q <= cfg_data;
					REG_START_ANGLE: angle_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.start && cmd.op == OP_RATE) begin
				rate_q <= sat32(66'(rin_q) - 66'(bias_q));
			end
			if (cmd.wb) begin
				unique case (cmd.op)
					OP_M_ANG, OP_M_CA: angle_q <= sat32(66'(angle_q) + 66'(mres));
					OP_M_CB:  bias_q <= sat32(66'(bias_q) + 66'(mres));
					OP_M_P00: begin
						p_q[0] <= sat40(66'(p_q[0]) + 66'(mres));
						p_q[1] <= sat40(66'(p_q[1]) - 66'(d11_q));
						p_q[2] <= sat40(66'(p_q[2]) - 66'(d11_q));
					end
					OP_M_P11: p_q[3] <= sat40(66'(p_q[3]) + 66'(mres));
					OP_M_C10: begin
						p_q[2] <= sat40(66'(p_q[2]) - 66'(mres));
						p_q[0] <= tmp_q;
					end
					OP_M_C11: begin
						p_q[3] <= sat40(66'(p_q[3]) - 66'(mres));
						p_q[1] <= tmp_q;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			meas_q <= measured_angle;
			rin_q  <= measured_rate;
			dt_q   <= time_step;
		end
		if (cmd.start) begin
			unique case (cmd.op)
				OP_INNER: inner_q <= 43'(d11_q) - 43'(p_q[1]) - 43'(p_q[2])
					+ 43'({q_angle_q, 8'b0});
				OP_S:     s_q <= 42'(p_q[0]) + 42'({r_measure_q, 8'b0});
				OP_Y:     y_q <= 33'(meas_q) - 33'(angle_q);
				default: ;
			endcase
		end
		if (cmd.wb) begin
			unique case (cmd.op)
				OP_M_D11: d11_q <= mres[39:0];
				OP_D_K0:  k0_q <= dres;
				OP_D_K1:  k1_q <= dres;
				OP_M_C00: tmp_q <= sat40(66'(p_q[0]) - 66'(mres));
				OP_M_C01: tmp_q <= sat40(66'(p_q[1]) - 66'(mres));
				default: ;
			endcase
		end
		if (cmd.emit) begin
			fa_q <= angle_q;
			ur_q <= rate_q;
		end
	end

	assign status.done     = mdone | ddone;
	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign filtered_angle  = fa_q;
	assign unbiased_rate   = ur_q;

endmodule

// ===== hdl/kab_ctrl.sv =====
// sequencer that walks the filter operations one after another
module kab_ctrl import kab_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_ISSUE = 4'b0010,
		S_WAIT  = 4'b0100,
		S_OUT   = 4'b1000
	} state_t;

	localparam op_t PROGRAM [NUM_OPS] = '{
		OP_RATE, OP_M_ANG, OP_M_D11, OP_INNER, OP_M_P00, OP_M_P11, OP_S, OP_D_K0,
		OP_D_K1, OP_Y, OP_M_CA, OP_M_CB, OP_M_C00, OP_M_C10, OP_M_C01, OP_M_C11
	};

	state_t     state_q;
	state_t     state_d;
	logic [3:0] step_q;
	logic [3:0] step_d;
	logic       last;

	assign last = step_q == 4'(NUM_OPS - 1);

	always_comb begin
		state_d   = state_q;
		step_d    = step_q;
		in_ready  = 1'b0;
		cmd.start = 1'b0;
		cmd.wb    = 1'b0;
		cmd.load  = 1'b0;
		cmd.emit  = 1'b0;
		cmd.op    = PROGRAM[step_q];
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					step_d   = '0;
					state_d  = S_ISSUE;
				end
			end
			S_ISSUE: begin
				cmd.start = 1'b1;
				if (op_is_alu(cmd.op)) begin
					if (last) state_d = S_OUT;
					else step_d = step_q + 4'd1;
				end else begin
					state_d = S_WAIT;
				end
			end
			S_WAIT: begin
				if (status.done) begin
					cmd.wb = 1'b1;
					if (last) begin
						state_d = S_OUT;
					end else begin
						step_d  = step_q + 4'd1;
						state_d = S_ISSUE;
					end
				end
			end
			S_OUT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state register not one-hot");
	a_load_seq: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_ISSUE) && (step_q == 4'd0))
		else $error("load did not restart the sequence");
	a_wait_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WAIT) && !status.done |=> (state_q == S_WAIT) && $stable(step_q))
		else $error("left wait without unit done");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> status.out_free)
		else $error("result emitted over a pending transaction");

endmodule

// ===== hdl/kalman_angle_bias_filter.sv =====
// top level of the two-state angle and gyro bias filter
// Each input transaction runs through sixteen operations in turn on one shared
// multiplier (ten products), one bit-serial divider (two gains) and four add
// steps, so a new item is taken only once the previous one has been through all
// of them; the divider takes the largest share of that time.
// A new item is accepted once the previous one has reached the output register,
// even while that result still waits to be taken. Configuration writes are
// taken in any cycle and belong to idle periods; writing start_angle also loads
// the angle estimate.
module kalman_angle_bias_filter import kab_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [31:0]  measured_angle,
	input  logic signed [31:0]  measured_rate,
	input  logic [15:0]         time_step,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  filtered_angle,
	output logic signed [31:0]  unbiased_rate
);

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	kab_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.status(status), .cmd(cmd)
	);

	kab_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.measured_angle(measured_angle), .measured_rate(measured_rate),
		.time_step(time_step), .out_valid(out_valid), .out_ready(out_ready),
		.filtered_angle(filtered_angle), .unbiased_rate(unbiased_rate)
	);

endmodule
